[rtl/rapc_pkg.sv]
// ----------------------------------------------------------------------------
// rapc_pkg
// Shared types and constants of the RGBA alpha premultiply converter.
// ----------------------------------------------------------------------------
package rapc_pkg;

    localparam int DIV_BITS    = 8;
    localparam int LANE_STAGES = DIV_BITS + 1;
    localparam int NUM_LANES   = 3;

    localparam logic [7:0]  FULL_SCALE  = 8'd255;
    localparam logic [15:0] PREMUL_BIAS = 16'd254;

    // Configuration register indexes.
    localparam logic [1:0] REG_DIRECTION     = 2'd0;
    localparam logic [1:0] REG_CONVERT_ALPHA = 2'd1;
    localparam logic [1:0] REG_SWAP_RED_BLUE = 2'd2;

    // Per-channel operation carried down a lane.
    localparam logic [1:0] OP_COPY = 2'd0;
    localparam logic [1:0] OP_SAT  = 2'd1;
    localparam logic [1:0] OP_DIV  = 2'd2;
    localparam logic [1:0] OP_PRE  = 2'd3;

    typedef struct packed {
        logic direction;
        logic convert_alpha;
        logic swap_red_blue;
    } rapc_cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] rem;
        logic [7:0]  quo;
        logic [7:0]  dvs;
    } rapc_lane_t;

endpackage

[rtl/rgba_alpha_premultiply_convert.sv]
// ----------------------------------------------------------------------------
// rgba_alpha_premultiply_convert
// Premultiplies or un-premultiplies one RGBA8888 pixel per unstalled clock.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel and leave on the m_ channel, both valid/ready;
// one beat carries one pixel. Three lanes, one per colour channel, each run a
// product stage and an eight-stage restoring divider (one quotient bit per
// stage); premultiply uses a multiply then an exact divide by 255. A merge
// register swaps channels 0 and 2 if asked and holds the result beat.
// Each pixel passes the entry stage, the divider stages and the merge register
// in turn; with the output not stalled, one pixel is taken per cycle.
// When the receiver stalls, the stall backs up stage by stage; empty stages
// keep filling, so s_ready drops only once every stage holds a pixel.
// Configuration registers (direction, convert_alpha, swap_red_blue) are
// written through cfg_wr_en/cfg_index/cfg_wdata; the user must do so only
// while the block is idle (the block does not enforce it). Synchronous reset
// empties the pipeline, loads direction 0, convert_alpha 1, swap_red_blue 0.
// ----------------------------------------------------------------------------
module rgba_alpha_premultiply_convert
    import rapc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_ch0,
    input  logic [7:0] s_in_ch1,
    input  logic [7:0] s_in_ch2,
    input  logic [7:0] s_in_alpha,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_ch0,
    output logic [7:0] m_out_ch1,
    output logic [7:0] m_out_ch2,
    output logic [7:0] m_out_alpha
);

    rapc_cfg_t              cfg_reg;
    logic [LANE_STAGES-1:0] valid_reg;
    logic                   out_valid_reg;
    logic [LANE_STAGES-1:0] adv;
    logic                   out_adv;
    logic [7:0]             alpha_reg [LANE_STAGES];
    logic [7:0]             lane_res [NUM_LANES];
    logic [7:0]             lane_in [NUM_LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.direction     <= 1'b0;
            cfg_reg.convert_alpha <= 1'b1;
            cfg_reg.swap_red_blue <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DIRECTION:     cfg_reg.direction     <= cfg_wdata;
                REG_CONVERT_ALPHA: cfg_reg.convert_alpha <= cfg_wdata;
                REG_SWAP_RED_BLUE: cfg_reg.swap_red_blue <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A stage moves on when it is empty or its successor moves on.
    always_comb begin
        out_adv = !out_valid_reg || m_ready;
        adv[LANE_STAGES-1] = !valid_reg[LANE_STAGES-1] || out_adv;
        for (int j = LANE_STAGES - 2; j >= 0; j--) begin
            adv[j] = !valid_reg[j] || adv[j+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int j = 1; j < LANE_STAGES; j++) begin
                if (adv[j]) begin
                    valid_reg[j] <= valid_reg[j-1];
                end
            end
            if (out_adv) begin
                out_valid_reg <= valid_reg[LANE_STAGES-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            alpha_reg[0] <= s_in_alpha;
        end
        for (int j = 1; j < LANE_STAGES; j++) begin
            if (adv[j]) begin
                alpha_reg[j] <= alpha_reg[j-1];
            end
        end
    end

    assign lane_in[0] = s_in_ch0;
    assign lane_in[1] = s_in_ch1;
    assign lane_in[2] = s_in_ch2;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        rapc_lane u_lane (
            .aclk   (aclk),
            .cfg    (cfg_reg),
            .adv    (adv),
            .chan   (lane_in[l]),
            .alpha  (s_in_alpha),
            .result (lane_res[l])
        );
    end

    rapc_merge u_merge (
        .aclk          (aclk),
        .load          (out_adv),
        .swap_red_blue (cfg_reg.swap_red_blue),
        .lane0         (lane_res[0]),
        .lane1         (lane_res[1]),
        .lane2         (lane_res[2]),
        .alpha         (alpha_reg[LANE_STAGES-1]),
        .ch0           (m_out_ch0),
        .ch1           (m_out_ch1),
        .ch2           (m_out_ch2),
        .ch_alpha      (m_out_alpha)
    );

    assign s_ready = adv[0];
    assign m_valid = out_valid_reg;

endmodule

[rtl/rapc_lane.sv]
// ----------------------------------------------------------------------------
// rapc_lane
// One colour channel: product stage followed by a bit-per-stage divider.
// ----------------------------------------------------------------------------
module rapc_lane
    import rapc_pkg::*;
(
    input  logic                   aclk,
    input  rapc_cfg_t              cfg,
    input  logic [LANE_STAGES-1:0] adv,
    input  logic [7:0]             chan,
    input  logic [7:0]             alpha,
    output logic [7:0]             result
);

    rapc_lane_t stage_reg [LANE_STAGES];
    rapc_lane_t entry_next;

    always_comb begin
        entry_next.op  = OP_COPY;
        entry_next.rem = '0;
        entry_next.quo = chan;
        entry_next.dvs = alpha;
        if (cfg.convert_alpha) begin
            if (cfg.direction) begin
                if (alpha != FULL_SCALE) begin
                    entry_next.op  = OP_PRE;
                    entry_next.rem = 16'(chan) * 16'(alpha) + PREMUL_BIAS;
                end
            end else if (alpha != 8'd0) begin
                // A colour at or above alpha gives a quotient of at least 255.
                if (chan >= alpha) begin
                    entry_next.op  = OP_SAT;
                    entry_next.quo = FULL_SCALE;
                end else begin
                    entry_next.op  = OP_DIV;
                    entry_next.rem = {chan, 8'd0} - {8'd0, chan};
                    entry_next.quo = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            stage_reg[0] <= entry_next;
        end
    end

    for (genvar k = 1; k < LANE_STAGES; k++) begin : g_step
        localparam int BitIdx = DIV_BITS - k;

        rapc_lane_t  prev;
        rapc_lane_t  stage_next;
        logic [15:0] trial;
        logic [16:0] pre_sum;

        always_comb begin
            prev       = stage_reg[k-1];
            stage_next = prev;
            trial      = {8'd0, prev.dvs} << BitIdx;
            // Exact x/255 for any x up to 65534: (x + 1 + x/256) / 256.
            pre_sum    = {1'b0, prev.rem} + 17'd1 + 17'(prev.rem[15:8]);
            unique case (prev.op)
                OP_DIV: begin
                    if (prev.rem >= trial) begin
                        stage_next.rem         = prev.rem - trial;
                        stage_next.quo[BitIdx] = 1'b1;
                    end
                end
                OP_PRE: begin
                    stage_next.quo = pre_sum[15:8];
                    stage_next.op  = OP_COPY;
                end
                OP_COPY, OP_SAT: begin
                end
            endcase
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                stage_reg[k] <= stage_next;
            end
        end
    end

    assign result = stage_reg[LANE_STAGES-1].quo;

endmodule

[rtl/rapc_merge.sv]
// ----------------------------------------------------------------------------
// rapc_merge
// Output register: gathers the lane results and applies the channel swap.
// ----------------------------------------------------------------------------
module rapc_merge
    import rapc_pkg::*;
(
    input  logic       aclk,
    input  logic       load,
    input  logic       swap_red_blue,
    input  logic [7:0] lane0,
    input  logic [7:0] lane1,
    input  logic [7:0] lane2,
    input  logic [7:0] alpha,
    output logic [7:0] ch0,
    output logic [7:0] ch1,
    output logic [7:0] ch2,
    output logic [7:0] ch_alpha
);

    logic [7:0] ch0_reg, ch1_reg, ch2_reg, alpha_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            ch0_reg   <= swap_red_blue ? lane2 : lane0;
            ch1_reg   <= lane1;
            ch2_reg   <= swap_red_blue ? lane0 : lane2;
            alpha_reg <= alpha;
        end
    end

    assign ch0      = ch0_reg;
    assign ch1      = ch1_reg;
    assign ch2      = ch2_reg;
    assign ch_alpha = alpha_reg;

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the RGBA alpha premultiply converter.
// ----------------------------------------------------------------------------
// A queue of pending pixels feeds a bursty valid/ready driver. Each accepted
// pixel is converted by a local predictor, which uses the testbench's own copy
// of the configuration registers. A monitor compares every result beat field
// by field with the oldest prediction. The receiver stalls on its own pattern,
// with long hold-offs that back the pipeline up. Configuration is changed only
// after the block has drained: a short directed set runs under three settings,
// then random pixels run under every combination of the three registers.
// ----------------------------------------------------------------------------
module tb
    import rapc_pkg::*;
();

    typedef struct packed {
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
        logic [7:0] alpha;
    } pixel_t;

    // Index past the last register; writes to it must have no effect.
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int RANDOM_PHASES    = 8;
    localparam int PIXELS_PER_PHASE = 56;
    localparam int DRAIN_CYCLES     = 14;
    localparam int LONG_HOLD_CYCLES = 48;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       cfg_wr_en  = 1'b0;
    logic [1:0] cfg_index  = REG_DIRECTION;
    logic       cfg_wdata  = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_ch0   = 8'd0;
    logic [7:0] s_in_ch1   = 8'd0;
    logic [7:0] s_in_ch2   = 8'd0;
    logic [7:0] s_in_alpha = 8'd0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_ch0;
    logic [7:0] m_out_ch1;
    logic [7:0] m_out_ch2;
    logic [7:0] m_out_alpha;

    rapc_cfg_t cfg_copy;
    pixel_t    pending_pixels[$];
    pixel_t    expected_pixels[$];
    int        mismatch_count = 0;
    int        stall_style    = 0;

    rgba_alpha_premultiply_convert dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_ch0    (s_in_ch0),
        .s_in_ch1    (s_in_ch1),
        .s_in_ch2    (s_in_ch2),
        .s_in_alpha  (s_in_alpha),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_ch0   (m_out_ch0),
        .m_out_ch1   (m_out_ch1),
        .m_out_ch2   (m_out_ch2),
        .m_out_alpha (m_out_alpha)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [7:0] scale_colour(logic [7:0] colour, logic [7:0] alpha,
                                                rapc_cfg_t cfg);
        int unsigned c;
        int unsigned a;
        int unsigned q;
        c = colour;
        a = alpha;
        if (!cfg.convert_alpha)
            return colour;
        if (cfg.direction) begin
            if (a == FULL_SCALE)
                return colour;
            q = (c * a + PREMUL_BIAS) / FULL_SCALE;
        end else begin
            if (a == 0)
                return colour;
            q = (c * FULL_SCALE) / a;
            // Colour above alpha is not a valid premultiplied value: clamp it.
            if (q > FULL_SCALE)
                q = FULL_SCALE;
        end
        return q[7:0];
    endfunction

    function automatic pixel_t convert_pixel(rapc_cfg_t cfg, pixel_t p);
        pixel_t r;
        logic [7:0] c0;
        logic [7:0] c2;
        c0 = scale_colour(p.ch0, p.alpha, cfg);
        c2 = scale_colour(p.ch2, p.alpha, cfg);
        r.ch1   = scale_colour(p.ch1, p.alpha, cfg);
        r.ch0   = cfg.swap_red_blue ? c2 : c0;
        r.ch2   = cfg.swap_red_blue ? c0 : c2;
        r.alpha = p.alpha;
        return r;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        case ($urandom_range(0, 9))
            0:       p.alpha = 8'd0;
            1:       p.alpha = 8'd255;
            default: p.alpha = 8'($urandom_range(0, 255));
        endcase
        // Mostly well-formed premultiplied colours, the rest anything at all.
        if ($urandom_range(0, 3) == 0) begin
            p.ch0 = 8'($urandom_range(0, 255));
            p.ch1 = 8'($urandom_range(0, 255));
            p.ch2 = 8'($urandom_range(0, 255));
        end else begin
            p.ch0 = 8'($urandom_range(0, p.alpha));
            p.ch1 = 8'($urandom_range(0, p.alpha));
            p.ch2 = 8'($urandom_range(0, p.alpha));
        end
        return p;
    endfunction

    task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
        $display("%0t: %s got %0d, predicted %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(logic [1:0] index, logic value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (index)
            REG_DIRECTION:     cfg_copy.direction     = value;
            REG_CONVERT_ALPHA: cfg_copy.convert_alpha = value;
            REG_SWAP_RED_BLUE: cfg_copy.swap_red_blue = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_directed();
        pending_pixels.push_back('{8'd0,   8'd0,   8'd0,   8'd0});
        pending_pixels.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
        pending_pixels.push_back('{8'd200, 8'd17,  8'd99,  8'd0});
        pending_pixels.push_back('{8'd1,   8'd128, 8'd254, 8'd255});
        pending_pixels.push_back('{8'd200, 8'd255, 8'd100, 8'd100});
        pending_pixels.push_back('{8'd1,   8'd0,   8'd1,   8'd1});
        pending_pixels.push_back('{8'hAA,  8'h55,  8'hAA,  8'h55});
        pending_pixels.push_back('{8'h55,  8'hAA,  8'h55,  8'hAA});
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        logic   next_valid;
        pixel_t p;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                expected_pixels.push_back(convert_pixel(cfg_copy,
                    '{s_in_ch0, s_in_ch1, s_in_ch2, s_in_alpha}));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_pixels.size() != 0) begin
                    p = pending_pixels.pop_front();
                    s_in_ch0   <= p.ch0;
                    s_in_ch1   <= p.ch1;
                    s_in_ch2   <= p.ch2;
                    s_in_alpha <= p.alpha;
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // Receiver: its own stall pattern, plus long hold-offs at a few beat counts.
    int          beats_taken = 0;
    int          hold_left   = 0;
    logic [15:0] stall_bits  = 16'h0;
    int          pattern_pos = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_taken++;
                if (beats_taken == 100 || beats_taken == 260 || beats_taken == 410)
                    hold_left = LONG_HOLD_CYCLES;
            end
            if (pattern_pos == 0)
                stall_bits = 16'($urandom_range(0, 16'hFFFF));
            pattern_pos = (pattern_pos + 1) % 16;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (stall_style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= stall_bits[pattern_pos] | stall_bits[15 - pattern_pos];
                endcase
            end
        end
    end

    // Monitor: every result beat against the oldest prediction.
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: result beat with no pixel outstanding", $time);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_out_ch0 !== want.ch0)
                    report_mismatch("out_ch0", m_out_ch0, want.ch0);
                if (m_out_ch1 !== want.ch1)
                    report_mismatch("out_ch1", m_out_ch1, want.ch1);
                if (m_out_ch2 !== want.ch2)
                    report_mismatch("out_ch2", m_out_ch2, want.ch2);
                if (m_out_alpha !== want.alpha)
                    report_mismatch("out_alpha", m_out_alpha, want.alpha);
            end
        end
    end

    initial begin
        cfg_copy.direction     = 1'b0;
        cfg_copy.convert_alpha = 1'b1;
        cfg_copy.swap_red_blue = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed set under reset settings, then premultiply, then swapped copy.
        queue_directed();
        wait_drained();
        write_reg(REG_DIRECTION, 1'b1);
        queue_directed();
        wait_drained();
        write_reg(REG_CONVERT_ALPHA, 1'b0);
        write_reg(REG_SWAP_RED_BLUE, 1'b1);
        write_reg(REG_SPARE, 1'b1);
        queue_directed();
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_reg(REG_DIRECTION, phase[0]);
            write_reg(REG_CONVERT_ALPHA, ~phase[1]);
            write_reg(REG_SWAP_RED_BLUE, phase[2]);
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_SPARE, 1'($urandom_range(0, 1)));
            stall_style = phase % 3;
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
                pending_pixels.push_back(random_pixel());
            wait_drained();
        end

        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("rgba_alpha_premultiply_convert: match");
        else
            $display("rgba_alpha_premultiply_convert: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("rgba_alpha_premultiply_convert: mismatch");
        $finish;
    end

endmodule
